@@ design/rcf_pkg.sv @@
// ----------------------------------------------------------------------------
// rcf_pkg: shared types and constants of the variable time step RC filter
// Holds the controller states, the command and status bundles between the
// controller and the datapath, and the fixed widths and constants of the
// time and gain arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

package rcf_pkg;

  // Field widths that are fixed by the word format.
  localparam int MS_W     = 10;
  localparam int SEC_W    = 16;
  localparam int CUTOFF_W = 17;
  localparam int TIME_W   = 26;
  localparam int FC628_W  = CUTOFF_W + 10;
  localparam int PROD_W   = 53;
  localparam int DEN_W    = PROD_W + 1;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = CUTOFF_W;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MODE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_CUTOFF = 1'b1;
  localparam logic [CUTOFF_W-1:0]  CUTOFF_RESET   = 17'd1000;

  // Arithmetic constants.
  localparam logic [9:0]        MS_PER_S     = 10'd1000;
  localparam logic [TIME_W-1:0] TIME_WRAP_MS = 26'd65536000;
  localparam logic [9:0]        TWO_PI_X100  = 10'd628;
  localparam logic [23:0]       RC_NUMER     = 24'd10000000;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TIME,
    S_DT,
    S_MUL,
    S_DEN,
    S_NUM,
    S_DIV,
    S_FILT,
    S_OUT
  } rcf_state_t;

  typedef struct packed {
    logic load;
    logic time_calc;
    logic dt_calc;
    logic mul;
    logic den_calc;
    logic div_init;
    logic div_step;
    logic filt;
    logic commit;
  } rcf_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } rcf_status_t;

endpackage

`default_nettype wire

@@ design/rcf_ctrl.sv @@
// ----------------------------------------------------------------------------
// rcf_ctrl: sequencer of the RC filter
// Steps one word at a time through timestamp, time step, gain division,
// filter product and result write.
// ----------------------------------------------------------------------------
`default_nettype none

module rcf_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  rcf_pkg::rcf_status_t   status,
  output rcf_pkg::rcf_cmd_t      cmd
);
  import rcf_pkg::*;

  rcf_state_t st;
  rcf_state_t st_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
    end else begin
      st <= st_next;
    end
  end

  always_comb begin
    st_next = st;
    case (st)
      S_IDLE: begin
        if (in_valid) st_next = S_TIME;
      end
      S_TIME: st_next = S_DT;
      S_DT:   st_next = S_MUL;
      S_MUL:  st_next = S_DEN;
      S_DEN:  st_next = S_NUM;
      S_NUM:  st_next = S_DIV;
      S_DIV: begin
        if (status.div_done) st_next = S_FILT;
      end
      S_FILT: st_next = S_OUT;
      S_OUT: begin
        if (status.out_free) st_next = S_IDLE;
      end
      default: st_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (st)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_TIME: cmd.time_calc = 1'b1;
      S_DT:   cmd.dt_calc   = 1'b1;
      S_MUL:  cmd.mul       = 1'b1;
      S_DEN:  cmd.den_calc  = 1'b1;
      S_NUM:  cmd.div_init  = 1'b1;
      S_DIV:  cmd.div_step  = 1'b1;
      S_FILT: cmd.filt      = 1'b1;
      S_OUT:  cmd.commit    = status.out_free;
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

  a_load_starts: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> st == S_TIME)
    else $error("accepted word did not start the sequence");

  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> status.out_free)
    else $error("result written over a word still waiting");

  a_div_exit: assert property (@(posedge clk) disable iff (rst)
    (st == S_DIV && status.div_done) |=> st == S_FILT)
    else $error("division did not hand over to the filter step");

endmodule

`default_nettype wire

@@ design/rcf_datapath.sv @@
// ----------------------------------------------------------------------------
// rcf_datapath: arithmetic and state of the RC filter
// Holds the configuration, the filter history, the restoring gain divider,
// the filter multiplier and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rcf_datapath #(
  parameter int SAMPLE_WIDTH   = 16,
  parameter int GAIN_FRAC_BITS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  rcf_pkg::rcf_cmd_t                        cmd,
  output rcf_pkg::rcf_status_t                     status,
  input  wire logic [rcf_pkg::MS_W-1:0]            time_ms,
  input  wire logic [rcf_pkg::SEC_W-1:0]           time_s,
  input  wire logic signed [SAMPLE_WIDTH-1:0]      sample_in,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]           sample_out,
  input  wire logic                                cfg_write,
  input  wire logic [rcf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [rcf_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import rcf_pkg::*;

  localparam int W     = SAMPLE_WIDTH;
  localparam int G     = GAIN_FRAC_BITS;
  localparam int Q_W   = G + 1;
  localparam int REM_W = DEN_W + 1;
  localparam int DSH_W = DEN_W + G;
  localparam int CNT_W = $clog2(Q_W);
  localparam int D_W   = W + 2;
  localparam int P_W   = W + G + 4;
  localparam int V_W   = P_W + 1;
  localparam int R_W   = V_W - G;

  localparam logic [REM_W-1:0] NumBase = REM_W'(RC_NUMER) << G;
  localparam logic [Q_W-1:0]   AlphaOne = Q_W'(1) << G;
  localparam logic signed [V_W-1:0] RoundHalf = V_W'(1) << (G - 1);
  localparam logic signed [R_W-1:0] SatHi = {{(R_W-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [R_W-1:0] SatLo = {{(R_W-W+1){1'b1}}, {(W-1){1'b0}}};

  // Configuration.
  logic                mode;
  logic [CUTOFF_W-1:0] cutoff;

  // Filter history.
  logic [TIME_W-1:0]   last_time;
  logic signed [W-1:0] last_input;
  logic signed [W-1:0] last_output;

  // Working registers of one word.
  logic [MS_W-1:0]     ms_r;
  logic [SEC_W-1:0]    s_r;
  logic signed [W-1:0] x_r;
  logic [TIME_W-1:0]   t_r;
  logic [FC628_W-1:0]  fc628;
  logic [TIME_W-1:0]   dt;
  logic [PROD_W-1:0]   prod;
  logic [DEN_W-1:0]    den;
  logic [REM_W-1:0]    rem;
  logic [DSH_W-1:0]    dsh;
  logic [Q_W-1:0]      quo;
  logic [CNT_W-1:0]    cnt;
  logic signed [P_W-1:0] fprod;

  // Combinational values.
  logic [TIME_W-1:0]   t_calc;
  logic [TIME_W:0]     wrap_sum;
  logic [TIME_W-1:0]   dt_calc;
  logic [DSH_W-1:0]    rem_ext;
  logic [DSH_W-1:0]    rem_sub;
  logic                rem_ge;
  logic [Q_W-1:0]      alpha;
  logic signed [D_W-1:0] yo_e;
  logic signed [D_W-1:0] xi_e;
  logic signed [D_W-1:0] xl_e;
  logic signed [D_W-1:0] diff;
  logic signed [P_W-1:0] fprod_calc;
  logic signed [V_W-1:0] lp_term;
  logic signed [V_W-1:0] vsum;
  logic signed [R_W-1:0] rounded;
  logic signed [W-1:0]   y_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= 1'b0;
      cutoff <= CUTOFF_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_IDX_MODE:   mode   <= cfg_data[0];
        CFG_IDX_CUTOFF: cutoff <= cfg_data[CUTOFF_W-1:0];
        default: ;
      endcase
    end
  end

  // Timestamp in milliseconds and the wrap-corrected time step.
  assign t_calc   = TIME_W'(s_r) * TIME_W'(MS_PER_S) + TIME_W'(ms_r);
  assign wrap_sum = {1'b0, t_r} + {1'b0, TIME_WRAP_MS} - {1'b0, last_time};
  assign dt_calc  = (t_r >= last_time) ? (t_r - last_time) : wrap_sum[TIME_W-1:0];

  // One restoring step of the gain division.
  assign rem_ext = DSH_W'(rem);
  assign rem_ge  = (rem_ext >= dsh);
  assign rem_sub = rem_ext - dsh;

  // The gain never exceeds one; the clamp keeps it there regardless.
  assign alpha = (quo > AlphaOne) ? AlphaOne : quo;

  // Low-pass is rewritten as alpha*(y - x) + x, so one product serves both modes.
  assign yo_e = D_W'(last_output);
  assign xi_e = D_W'(x_r);
  assign xl_e = D_W'(last_input);
  assign diff = mode ? (yo_e + xi_e - xl_e) : (yo_e - xi_e);
  assign fprod_calc = P_W'($signed({1'b0, alpha})) * P_W'(diff);

  assign lp_term = mode ? '0 : (V_W'(x_r) <<< G);
  assign vsum    = V_W'(fprod) + lp_term + RoundHalf;
  assign rounded = vsum[V_W-1:G];
  always_comb begin
    if (rounded > SatHi) begin
      y_sat = SatHi[W-1:0];
    end else if (rounded < SatLo) begin
      y_sat = SatLo[W-1:0];
    end else begin
      y_sat = rounded[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ms_r <= time_ms;
      s_r  <= time_s;
      x_r  <= sample_in;
    end
    if (cmd.time_calc) begin
      t_r   <= t_calc;
      fc628 <= FC628_W'(cutoff) * FC628_W'(TWO_PI_X100);
    end
    if (cmd.dt_calc) begin
      dt <= dt_calc;
    end
    if (cmd.mul) begin
      prod <= PROD_W'(fc628) * PROD_W'(dt);
    end
    if (cmd.den_calc) begin
      den <= DEN_W'(prod) + DEN_W'(RC_NUMER);
    end
    if (cmd.div_init) begin
      rem <= NumBase + REM_W'(den >> 1);
      dsh <= DSH_W'(den) << G;
      quo <= '0;
      cnt <= CNT_W'(G);
    end else if (cmd.div_step) begin
      if (rem_ge) begin
        rem <= rem_sub[REM_W-1:0];
      end
      quo <= {quo[Q_W-2:0], rem_ge};
      dsh <= dsh >> 1;
      cnt <= cnt - CNT_W'(1);
    end
    if (cmd.filt) begin
      fprod <= fprod_calc;
    end
    if (cmd.commit) begin
      sample_out <= y_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_time   <= '0;
      last_input  <= '0;
      last_output <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.commit) begin
        last_time   <= t_r;
        last_input  <= x_r;
        last_output <= y_sat;
        out_valid   <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign status.div_done = (cnt == '0);
  assign status.out_free = !out_valid || out_ready;

  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> ({1'b0, rem_ext} < {dsh, 1'b0}))
    else $error("gain quotient grew past its width");

  a_commit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("written result not offered");

endmodule

`default_nettype wire

@@ design/rc_filter_variable_timestep_core.sv @@
// ----------------------------------------------------------------------------
// rc_filter_variable_timestep_core: first-order RC filter, variable time step
// Filters timestamped samples low-pass or high-pass with a gain taken from
// the cutoff register and the time since the previous sample.
// ----------------------------------------------------------------------------
// Usage. Each input word carries a timestamp (time_s seconds, time_ms
// milliseconds) and a signed sample; it is taken when in_valid and in_ready
// are high at a clock edge. Each word yields exactly one output word on the
// out_valid/out_ready channel. The filter history (last time, input and
// output) is shared by both modes and is cleared by reset, so the first word
// after reset sees the whole timestamp as its time step.
//
// Sequencing. A word is worked on alone: a new word is taken only once the
// one before it is in the output register. The gain division is a restoring
// divider that makes one quotient bit a cycle, GAIN_FRAC_BITS + 1 bits in all.
//
// Stalls. The result sits in an output register. If the receiver stalls with a
// result still held, the next word is accepted and computed, and waits in its
// last step until the output register is taken. Configuration writes
// (filter_mode at index 0, cutoff_centihz at index 1) take effect at once and
// are to be made only while no word is in flight. Reset sets low-pass mode and
// a cutoff of 10 Hz.
// ----------------------------------------------------------------------------
`default_nettype none

module rc_filter_variable_timestep_core #(
  parameter int SAMPLE_WIDTH   = 16,
  parameter int GAIN_FRAC_BITS = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [rcf_pkg::MS_W-1:0]         time_ms,
  input  wire logic [rcf_pkg::SEC_W-1:0]        time_s,
  input  wire logic signed [SAMPLE_WIDTH-1:0]   sample_in,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]        sample_out,
  input  wire logic                             cfg_write,
  input  wire logic [rcf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [rcf_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import rcf_pkg::*;

  // Commands from the sequencer and the status it steers by.
  rcf_cmd_t    cmd;
  rcf_status_t status;

  rcf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  rcf_datapath #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .time_ms    (time_ms),
    .time_s     (time_s),
    .sample_in  (sample_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb: self-checking bench for the variable time step RC filter core
// Drives timestamped sample words through the filter, low-pass and high-pass,
// under several cutoff settings and randomized idling on both channels. Each
// word that is taken is run through an independent filter predictor. Each
// word that comes back is compared with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

  import rcf_pkg::*;

  // Arithmetic of the predictor. The gain is RC/(RC+dt) with everything in
  // milliseconds, which becomes 1e7 / (1e7 + 628*fc*dt) with fc in centihertz.
  localparam int               GAIN_FRAC_BITS = 16;
  localparam longint unsigned  GAIN_ONE       = 64'd1 << GAIN_FRAC_BITS;
  localparam longint           ROUND_HALF     = 64'sd1 <<< (GAIN_FRAC_BITS - 1);
  localparam longint unsigned  RC_SCALE       = 64'd10000000;
  localparam longint unsigned  TWO_PI_CENTI   = 64'd628;
  localparam longint unsigned  MS_IN_SEC      = 64'd1000;
  localparam longint unsigned  STAMP_WRAP     = 64'd65536000;
  localparam longint           SAMPLE_MAX     = 64'sd32767;
  localparam longint           SAMPLE_MIN     = -64'sd32768;

  localparam int  RANDOM_WORDS = 300;
  localparam int  SEGMENTS     = 6;
  localparam int  HOLD_CYCLES  = 400;
  localparam int  DRAIN_CYCLES = 50;
  localparam int  CYCLE_LIMIT  = 500000;
  localparam int  REPORT_MAX   = 10;

  // Directed rows are either a sample word or a register write.
  typedef enum logic {ROW_SAMPLE, ROW_CONFIG} row_kind_t;

  typedef struct packed {
    row_kind_t                 kind;
    logic [CFG_IDX_W-1:0]      reg_idx;
    logic [CFG_DATA_W-1:0]     reg_val;
    logic [MS_W-1:0]           ms;
    logic [SEC_W-1:0]          sec;
    logic signed [15:0]        x;
    logic                      typed;
    logic signed [15:0]        typed_y;
  } dir_row_t;

  localparam int DIR_ROWS = 24;

  // The first rows run at a zero time step or an enormous one, so the gain is
  // exactly one or exactly zero and the result can be written down directly.
  // The others exercise the seconds wrap, milliseconds past 999, a zero
  // cutoff, a mode write with junk in the upper bits and the cutoff extremes.
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{ROW_SAMPLE, CFG_IDX_MODE,   17'd0,      10'd0,    16'd0,     16'sd1234,  1'b1, 16'sd0},
    '{ROW_SAMPLE, CFG_IDX_MODE,   17'd0,      10'd0,    16'd0,     16'h8000,   1'b1, 16'sd0},
    '{ROW_SAMPLE, CFG_IDX_MODE,   17'd0,      10'd999,  16'd65535, 16'h7FFF,   1'b1, 16'h7FFF},
    '{ROW_SAMPLE, CFG_IDX_MODE,   17'd0,      10'd999,  16'd65535, 16'h8000,   1'b1, 16'h7FFF},
    '{ROW_CONFIG, CFG_IDX_MODE,   17'h1FFFF,  10'd0,    16'd0,     16'sd0,     1'b0, 16'sd0},
    '{ROW_SAMPLE, CFG_IDX_MODE,   17'd0,      10'd999,  16'd65535, 16'h7FFF,   1'b1, 16'h7FFF},
    '{ROW_SAMPLE, CFG_IDX_MODE,   17'd0,      10'd999,  16'd65535, 16'h8000,   1'b1, 16'h8000},
    '{ROW_SAMPLE, CFG_IDX_MODE,   17'd0,      10'd5,    16'd0,     16'sd100,   1'b0, 16'sd0},
    '{ROW_SAMPLE, CFG_IDX_MODE,   17'd0,      10'd1023, 16'd0,     -16'sd100,  1'b0, 16'sd0},
    '{ROW_SAMPLE, CFG_IDX_MODE,   17'd0,      10'd0,    16'd1,     16'h8000,   1'b0, 16'sd0},
    '{ROW_CONFIG, CFG_IDX_CUTOFF, 17'd0,      10'd0,    16'd0,     16'sd0,     1'b0, 16'sd0},
    '{ROW_SAMPLE, CFG_IDX_MODE,   17'd0,      10'd500,  16'd100,   16'sd5000,  1'b0, 16'sd0},
    '{ROW_CONFIG, CFG_IDX_MODE,   17'h00002,  10'd0,    16'd0,     16'sd0,     1'b0, 16'sd0},
    '{ROW_SAMPLE, CFG_IDX_MODE,   17'd0,      10'd500,  16'd200,   -16'sd7,    1'b0, 16'sd0},
    '{ROW_CONFIG, CFG_IDX_CUTOFF, 17'h1FFFF,  10'd0,    16'd0,     16'sd0,     1'b0, 16'sd0},
    '{ROW_SAMPLE, CFG_IDX_MODE,   17'd0,      10'd1,    16'd200,   16'sd30000, 1'b0, 16'sd0},
    '{ROW_SAMPLE, CFG_IDX_MODE,   17'd0,      10'd2,    16'd200,   -16'sd30000, 1'b0, 16'sd0},
    '{ROW_CONFIG, CFG_IDX_CUTOFF, 17'd1,      10'd0,    16'd0,     16'sd0,     1'b0, 16'sd0},
    '{ROW_SAMPLE, CFG_IDX_MODE,   17'd0,      10'd0,    16'd300,   16'sd20000, 1'b0, 16'sd0},
    '{ROW_CONFIG, CFG_IDX_CUTOFF, 17'd100000, 10'd0,    16'd0,     16'sd0,     1'b0, 16'sd0},
    '{ROW_CONFIG, CFG_IDX_MODE,   17'd1,      10'd0,    16'd0,     16'sd0,     1'b0, 16'sd0},
    '{ROW_SAMPLE, CFG_IDX_MODE,   17'd0,      10'd3,    16'd300,   -16'sd1,    1'b0, 16'sd0},
    '{ROW_SAMPLE, CFG_IDX_MODE,   17'd0,      10'd4,    16'd300,   16'h7FFF,   1'b0, 16'sd0},
    '{ROW_SAMPLE, CFG_IDX_MODE,   17'd0,      10'd4,    16'd300,   16'sd0,     1'b0, 16'sd0}
  };

  logic                    clk = 1'b0;
  logic                    rst;
  logic                    in_valid;
  logic                    in_ready;
  logic [MS_W-1:0]         time_ms;
  logic [SEC_W-1:0]        time_s;
  logic signed [15:0]      sample_in;
  logic                    out_valid;
  logic                    out_ready;
  logic signed [15:0]      sample_out;
  logic                    cfg_write;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;

  // Predictor copy of the registers and of the shared filter history.
  logic                    hp_mode;
  logic [CUTOFF_W-1:0]     cutoff_cfg;
  longint unsigned         prev_stamp;
  longint                  prev_x;
  longint                  prev_y;

  // Filtered samples that the core still owes, oldest first.
  logic signed [15:0]      filtered_due [$];

  int                      errors;
  int                      cycle_count;
  int                      send_idle_pct;
  int                      recv_idle_pct;
  logic                    hold_req;
  int                      hold_left;

  rc_filter_variable_timestep_core i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .time_ms    (time_ms),
    .time_s     (time_s),
    .sample_in  (sample_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Runs one word through the predictor: works out the time step with the
  // seconds wrap corrected, the rounded gain, the filter update and the
  // saturation, and advances the history exactly as the core should.
  function automatic logic signed [15:0] rc_filter_next(input logic [MS_W-1:0] ms,
                                                         input logic [SEC_W-1:0] sec,
                                                         input logic signed [15:0] x);
    longint unsigned stamp;
    longint unsigned step;
    longint unsigned denom;
    longint unsigned alpha;
    longint          xin;
    longint          acc;
    stamp = longint'(sec) * MS_IN_SEC + longint'(ms);
    if (stamp >= prev_stamp) begin
      step = stamp - prev_stamp;
    end else begin
      step = stamp + STAMP_WRAP - prev_stamp;
    end
    denom = RC_SCALE + TWO_PI_CENTI * longint'(cutoff_cfg) * step;
    alpha = ((RC_SCALE << GAIN_FRAC_BITS) + denom / 2) / denom;
    if (alpha > GAIN_ONE) begin
      alpha = GAIN_ONE;
    end
    xin = x;
    if (hp_mode) begin
      acc = signed'(alpha) * (prev_y + xin - prev_x);
    end else begin
      acc = signed'(alpha) * prev_y + signed'(GAIN_ONE - alpha) * xin;
    end
    // Round to nearest with ties upward, then clamp to the sample range.
    acc = (acc + ROUND_HALF) >>> GAIN_FRAC_BITS;
    if (acc > SAMPLE_MAX) begin
      acc = SAMPLE_MAX;
    end else if (acc < SAMPLE_MIN) begin
      acc = SAMPLE_MIN;
    end
    prev_stamp = stamp & 64'h3FFFFFF;
    prev_x     = xin;
    prev_y     = acc;
    return acc[15:0];
  endfunction

  // Offers one sample word, after a random gap, and holds it until it is
  // taken. The expectation is queued at the edge that accepts the word. Rows
  // with a hand-written result queue that value instead, while the history
  // still moves on through the predictor.
  task automatic offer_sample(input logic [MS_W-1:0] ms, input logic [SEC_W-1:0] sec,
                              input logic signed [15:0] x, input logic typed,
                              input logic signed [15:0] typed_y);
    logic signed [15:0] want;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid  = 1'b1;
    time_ms   = ms;
    time_s    = sec;
    sample_in = x;
    do begin
      @(posedge clk);
    end while (!in_ready);
    want = rc_filter_next(ms, sec, x);
    filtered_due.push_back(typed ? typed_y : want);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Waits until every owed word has come back, so the core is idle.
  task automatic wait_drained();
    while (filtered_due.size() != 0) begin
      @(posedge clk);
    end
    @(negedge clk);
  endtask

  // One register write; the predictor keeps only the bits the core keeps.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    if (idx == CFG_IDX_MODE) begin
      hp_mode = val[0];
    end else begin
      cutoff_cfg = val;
    end
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  // Result checker. A word is taken when out_valid and out_ready are both
  // high at the rising edge; it must match the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (filtered_due.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX) begin
          $display("unexpected output word %0d", sample_out);
        end
      end else if (sample_out !== filtered_due[0]) begin
        errors++;
        if (errors <= REPORT_MAX) begin
          $display("sample_out mismatch: expected %0d, got %0d",
                   filtered_due[0], sample_out);
        end
        void'(filtered_due.pop_front());
      end else begin
        void'(filtered_due.pop_front());
      end
    end
  end

  // Receiver. Normally it stalls at the phase's rate; on request it holds
  // off for a long stretch so that the output register and the word behind
  // it both fill and the core has to refuse new input.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (rst) begin
      out_ready = 1'b0;
    end else if (hold_left != 0) begin
      out_ready = 1'b0;
      hold_left--;
    end else begin
      out_ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  initial begin
    longint unsigned    stream_ms;
    logic [MS_W-1:0]    ms_word;
    logic [SEC_W-1:0]   sec_word;
    logic signed [15:0] x_word;
    logic [CFG_DATA_W-1:0] cutoff_word;
    int                 pick;

    rst           = 1'b1;
    in_valid      = 1'b0;
    time_ms       = '0;
    time_s        = '0;
    sample_in     = '0;
    out_ready     = 1'b0;
    cfg_write     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    hold_req      = 1'b0;
    hold_left     = 0;
    errors        = 0;
    cycle_count   = 0;
    send_idle_pct = 38;
    recv_idle_pct = 79;

    // Reset values of the registers and the cleared history.
    hp_mode    = 1'b0;
    cutoff_cfg = 17'd1000;
    prev_stamp = 0;
    prev_x     = 0;
    prev_y     = 0;
    stream_ms  = 0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part. Register writes are only made once the core is empty.
    for (int r = 0; r < DIR_ROWS; r++) begin
      if (dir_rows[r].kind == ROW_CONFIG) begin
        wait_drained();
        write_reg(dir_rows[r].reg_idx, dir_rows[r].reg_val);
      end else begin
        offer_sample(dir_rows[r].ms, dir_rows[r].sec, dir_rows[r].x,
                     dir_rows[r].typed, dir_rows[r].typed_y);
      end
    end

    // Random part, in segments. Each segment starts from an idle core with a
    // new mode and cutoff. In the first pair of segments the receiver idles most,
    // in the second pair the sender does, and the last pair runs at full speed and
    // opens with a long receiver hold-off.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      wait_drained();
      case (seg)
        0:       cutoff_word = 17'd1;
        1:       cutoff_word = 17'd100000;
        2:       cutoff_word = 17'h1FFFF;
        3:       cutoff_word = 17'($urandom_range(1, 100000));
        4:       cutoff_word = 17'd1000;
        default: cutoff_word = 17'($urandom_range(1, 5000));
      endcase
      // The upper bits of the mode word are noise; only bit 0 counts.
      write_reg(CFG_IDX_MODE, {16'($urandom), 1'(seg)});
      write_reg(CFG_IDX_CUTOFF, cutoff_word);
      if (seg < 2) begin
        send_idle_pct = 38;
        recv_idle_pct = 79;
      end else if (seg < 4) begin
        send_idle_pct = 79;
        recv_idle_pct = 38;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (seg == 4) begin
        hold_req = 1'b1;
      end
      for (int n = 0; n < RANDOM_WORDS; n++) begin
        // Timestamps mostly march forward by realistic steps, so the gain
        // covers its whole range; now and then the stream repeats a stamp,
        // jumps anywhere, parks just before the seconds wrap, or carries a
        // millisecond count past 999.
        pick = $urandom_range(99);
        if (pick < 8) begin
          // same timestamp again
        end else if (pick < 68) begin
          stream_ms = stream_ms + $urandom_range(1, 50);
        end else if (pick < 88) begin
          stream_ms = stream_ms + $urandom_range(51, 5000);
        end else if (pick < 93) begin
          stream_ms = longint'($urandom_range(0, 65535)) * MS_IN_SEC + $urandom_range(0, 999);
        end else if (pick < 97) begin
          stream_ms = 64'd65535 * MS_IN_SEC + $urandom_range(0, 999);
        end
        stream_ms = stream_ms % STAMP_WRAP;
        sec_word  = 16'(stream_ms / MS_IN_SEC);
        ms_word   = 10'(stream_ms % MS_IN_SEC);
        if (pick >= 97) begin
          ms_word = 10'($urandom_range(1000, 1023));
        end
        case ($urandom_range(9))
          0:       x_word = 16'h7FFF;
          1:       x_word = 16'h8000;
          default: x_word = 16'($urandom);
        endcase
        offer_sample(ms_word, sec_word, x_word, 1'b0, 16'sd0);
      end
    end

    // All words are in; let the last ones drain, then watch a little longer
    // for anything the core should not have produced.
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
